// ===== hdl/c_ts_pkg.sv =====
`default_nettype none

package c_ts_pkg;

  // Result field widths
  localparam int unsigned KIND_W   = 6;
  localparam int unsigned START_W  = 32;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 3;

  // Defaults for the top level parameters
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 4;

  // Input action codes
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_EOI  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CHAR    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ELLIPSIS = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CHAR_LIT    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OPEN_STRING = 3'd4;

  // Token kinds: single punctuators
  localparam logic [KIND_W-1:0] K_LPAREN = 6'd0;
  localparam logic [KIND_W-1:0] K_RPAREN = 6'd1;
  localparam logic [KIND_W-1:0] K_LBRACE = 6'd2;
  localparam logic [KIND_W-1:0] K_RBRACE = 6'd3;
  localparam logic [KIND_W-1:0] K_LBRACK = 6'd4;
  localparam logic [KIND_W-1:0] K_RBRACK = 6'd5;
  localparam logic [KIND_W-1:0] K_SEMI   = 6'd6;
  localparam logic [KIND_W-1:0] K_COLON  = 6'd7;
  localparam logic [KIND_W-1:0] K_COMMA  = 6'd8;
  localparam logic [KIND_W-1:0] K_TILDE  = 6'd9;
  localparam logic [KIND_W-1:0] K_QUEST  = 6'd10;
  // Punctuators that may take a second character
  localparam logic [KIND_W-1:0] K_NOT    = 6'd11;
  localparam logic [KIND_W-1:0] K_PLUS   = 6'd12;
  localparam logic [KIND_W-1:0] K_MINUS  = 6'd13;
  localparam logic [KIND_W-1:0] K_STAR   = 6'd14;
  localparam logic [KIND_W-1:0] K_SLASH  = 6'd15;
  localparam logic [KIND_W-1:0] K_PCT    = 6'd16;
  localparam logic [KIND_W-1:0] K_AMP    = 6'd17;
  localparam logic [KIND_W-1:0] K_OR     = 6'd18;
  localparam logic [KIND_W-1:0] K_XOR    = 6'd19;
  localparam logic [KIND_W-1:0] K_ASSIGN = 6'd20;
  // Distance from an operator to its compound-assign form
  localparam logic [KIND_W-1:0] K_EQ_SHIFT = 6'd10;
  localparam logic [KIND_W-1:0] K_INC    = 6'd31;
  localparam logic [KIND_W-1:0] K_DEC    = 6'd32;
  localparam logic [KIND_W-1:0] K_ARROW  = 6'd33;
  localparam logic [KIND_W-1:0] K_LAND   = 6'd34;
  localparam logic [KIND_W-1:0] K_LOR    = 6'd35;
  localparam logic [KIND_W-1:0] K_LT     = 6'd36;
  localparam logic [KIND_W-1:0] K_GT     = 6'd37;
  localparam logic [KIND_W-1:0] K_LE     = 6'd38;
  localparam logic [KIND_W-1:0] K_GE     = 6'd39;
  localparam logic [KIND_W-1:0] K_SHL    = 6'd40;
  localparam logic [KIND_W-1:0] K_SHR    = 6'd41;
  localparam logic [KIND_W-1:0] K_SHLEQ  = 6'd42;
  localparam logic [KIND_W-1:0] K_SHREQ  = 6'd43;
  localparam logic [KIND_W-1:0] K_PERIOD = 6'd44;
  localparam logic [KIND_W-1:0] K_ELLIPSIS = 6'd45;
  localparam logic [KIND_W-1:0] K_IDENT  = 6'd46;
  localparam logic [KIND_W-1:0] K_INT    = 6'd47;
  localparam logic [KIND_W-1:0] K_FLOAT  = 6'd48;
  localparam logic [KIND_W-1:0] K_STRING = 6'd49;
  localparam logic [KIND_W-1:0] K_EOF    = 6'd50;
  localparam logic [KIND_W-1:0] K_NONE   = 6'd0;

  // Characters with a role of their own
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_USCORE  = 8'h5F;

  // Scanner modes
  typedef enum logic [3:0] {
    M_DEFAULT,
    M_MAYBE_DOUBLE,
    M_MAYBE_DT,
    M_MAYBE_TRIPLE,
    M_MAYBE_DOTS,
    M_NEED_DOT,
    M_IDENT,
    M_INT,
    M_FLOAT,
    M_STRING
  } mode_e;

  typedef struct packed {
    logic [KIND_W-1:0]   token_kind;
    logic [START_W-1:0]  start_offset;
    logic [LEN_W-1:0]    token_length;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  // Up to two results written to the queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
  } kind_hit_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha_us(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_USCORE);
  endfunction

  // space, tab, LF, VT, FF, CR
  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  // Punctuators that are always one character long
  function automatic kind_hit_t single_kind(logic [7:0] c);
    kind_hit_t r;
    r.hit = 1'b1;
    case (c)
      8'h28:   r.kind = K_LPAREN;  // (
      8'h29:   r.kind = K_RPAREN;  // )
      8'h7B:   r.kind = K_LBRACE;  // {
      8'h7D:   r.kind = K_RBRACE;  // }
      8'h5B:   r.kind = K_LBRACK;  // [
      8'h5D:   r.kind = K_RBRACK;  // ]
      8'h3B:   r.kind = K_SEMI;    // ;
      8'h3A:   r.kind = K_COLON;   // :
      8'h2C:   r.kind = K_COMMA;   // ,
      8'h7E:   r.kind = K_TILDE;   // ~
      8'h3F:   r.kind = K_QUEST;   // ?
      default: begin
        r.hit  = 1'b0;
        r.kind = K_NONE;
      end
    endcase
    return r;
  endfunction

  // Punctuators that may be followed by '=', a repeat or (for '-') '>'
  function automatic kind_hit_t double_kind(logic [7:0] c);
    kind_hit_t r;
    r.hit = 1'b1;
    case (c)
      8'h21:    r.kind = K_NOT;     // !
      CH_PLUS:  r.kind = K_PLUS;
      CH_MINUS: r.kind = K_MINUS;
      8'h2A:    r.kind = K_STAR;    // *
      8'h2F:    r.kind = K_SLASH;   // /
      8'h25:    r.kind = K_PCT;     // %
      CH_AMP:   r.kind = K_AMP;
      CH_BAR:   r.kind = K_OR;
      8'h5E:    r.kind = K_XOR;     // ^
      CH_EQ:    r.kind = K_ASSIGN;
      default: begin
        r.hit  = 1'b0;
        r.kind = K_NONE;
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/c_ts_in_if.sv =====
`default_nettype none

// Source byte channel
interface c_ts_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_byte;

  modport source (output valid, output action, output char_byte, input ready);
  modport sink   (input valid, input action, input char_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/c_ts_out_if.sv =====
`default_nettype none

// Token channel
interface c_ts_out_if;
  logic                              valid;
  logic                              ready;
  logic [c_ts_pkg::KIND_W-1:0]       token_kind;
  logic [c_ts_pkg::START_W-1:0]      start_offset;
  logic [c_ts_pkg::LEN_W-1:0]        token_length;
  logic [c_ts_pkg::STATUS_W-1:0]     status;
  logic                              last;

  modport source (output valid, output token_kind, output start_offset,
                  output token_length, output status, output last, input ready);
  modport sink   (input valid, input token_kind, input start_offset,
                  input token_length, input status, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/c_ts_front.sv =====
`default_nettype none

// Scanner front end: takes one byte per cycle while the queue has room,
// advances the token state and writes up to two finished tokens into the queue.
module c_ts_front #(
  parameter int unsigned OFFSET_BITS = c_ts_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = c_ts_pkg::LENGTH_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  c_ts_in_if.sink              in_i,
  input  wire logic            space_ok_i,
  output c_ts_pkg::push_t      push_o
);

  localparam int unsigned KindW  = c_ts_pkg::KIND_W;
  localparam int unsigned StartW = c_ts_pkg::START_W;
  localparam int unsigned LenW   = c_ts_pkg::LEN_W;

  // Scanner state
  c_ts_pkg::mode_e          mode_q, mode_d;
  logic [KindW-1:0]         kind_q, kind_d;
  logic [OFFSET_BITS-1:0]   start_q, start_d;
  logic [LENGTH_BITS-1:0]   len_q, len_d;
  logic [OFFSET_BITS-1:0]   off_q, off_d;
  logic                     esc_q, esc_d;
  logic                     closed_q, closed_d;

  logic                     accept;
  logic [7:0]               ch;
  logic [LENGTH_BITS-1:0]   len_grow;

  // Extension of the pending token
  logic                     e_emit;
  logic [KindW-1:0]         e_kind;
  logic [LENGTH_BITS-1:0]   e_len;
  logic [c_ts_pkg::STATUS_W-1:0] e_status;
  logic                     e_fresh;
  c_ts_pkg::mode_e          e_mode;
  logic [KindW-1:0]         e_pkind;
  logic [LENGTH_BITS-1:0]   e_lnext;
  logic                     e_esc;
  logic                     e_closed;

  // Scan of the byte as a token start
  logic                     f_emit;
  logic [KindW-1:0]         f_kind;
  logic [c_ts_pkg::STATUS_W-1:0] f_status;
  logic                     f_begin;
  logic [KindW-1:0]         f_bkind;
  c_ts_pkg::mode_e          f_bmode;
  logic                     f_string;
  logic                     do_fresh;

  function automatic c_ts_pkg::result_t mk_res(logic [KindW-1:0] kind,
                                               logic [OFFSET_BITS-1:0] start,
                                               logic [LENGTH_BITS-1:0] len,
                                               logic [c_ts_pkg::STATUS_W-1:0] st);
    c_ts_pkg::result_t r;
    r.token_kind   = kind;
    r.start_offset = StartW'(start);
    r.token_length = LenW'(len);
    r.status       = st;
    r.last         = 1'b0;
    return r;
  endfunction

  assign in_i.ready = space_ok_i;
  assign accept     = in_i.valid && space_ok_i;
  assign ch         = in_i.char_byte;
  assign len_grow   = (&len_q) ? len_q : len_q + LENGTH_BITS'(1);
  assign do_fresh   = e_fresh;

  // Offer the byte to the pending token
  always_comb begin
    c_ts_pkg::kind_hit_t dbl;
    dbl      = '{hit: 1'b0, kind: kind_q};
    e_emit   = 1'b0;
    e_kind   = kind_q;
    e_len    = len_q;
    e_status = c_ts_pkg::ST_OK;
    e_fresh  = 1'b0;
    e_mode   = mode_q;
    e_pkind  = kind_q;
    e_lnext  = len_q;
    e_esc    = esc_q;
    e_closed = closed_q;
    case (mode_q)
      c_ts_pkg::M_DEFAULT: begin
        e_fresh = 1'b1;
      end
      c_ts_pkg::M_MAYBE_DOUBLE: begin
        if (ch == c_ts_pkg::CH_EQ) begin
          dbl = '{hit: 1'b1, kind: kind_q + c_ts_pkg::K_EQ_SHIFT};
        end else if (ch == c_ts_pkg::CH_PLUS && kind_q == c_ts_pkg::K_PLUS) begin
          dbl = '{hit: 1'b1, kind: c_ts_pkg::K_INC};
        end else if (ch == c_ts_pkg::CH_MINUS && kind_q == c_ts_pkg::K_MINUS) begin
          dbl = '{hit: 1'b1, kind: c_ts_pkg::K_DEC};
        end else if (ch == c_ts_pkg::CH_GT && kind_q == c_ts_pkg::K_MINUS) begin
          dbl = '{hit: 1'b1, kind: c_ts_pkg::K_ARROW};
        end else if (ch == c_ts_pkg::CH_AMP && kind_q == c_ts_pkg::K_AMP) begin
          dbl = '{hit: 1'b1, kind: c_ts_pkg::K_LAND};
        end else if (ch == c_ts_pkg::CH_BAR && kind_q == c_ts_pkg::K_OR) begin
          dbl = '{hit: 1'b1, kind: c_ts_pkg::K_LOR};
        end
        e_emit = 1'b1;
        e_mode = c_ts_pkg::M_DEFAULT;
        e_kind = dbl.kind;
        if (dbl.hit) begin
          e_len   = len_grow;
          e_lnext = len_grow;
        end else begin
          e_fresh = 1'b1;
        end
      end
      c_ts_pkg::M_MAYBE_DT: begin
        if (ch == c_ts_pkg::CH_EQ) begin
          e_emit  = 1'b1;
          e_len   = len_grow;
          e_lnext = len_grow;
          e_kind  = (kind_q == c_ts_pkg::K_LT) ? c_ts_pkg::K_LE : c_ts_pkg::K_GE;
          e_mode  = c_ts_pkg::M_DEFAULT;
        end else if ((ch == c_ts_pkg::CH_LT && kind_q == c_ts_pkg::K_LT) ||
                     (ch == c_ts_pkg::CH_GT && kind_q == c_ts_pkg::K_GT)) begin
          e_lnext = len_grow;
          e_pkind = (kind_q == c_ts_pkg::K_LT) ? c_ts_pkg::K_SHL : c_ts_pkg::K_SHR;
          e_mode  = c_ts_pkg::M_MAYBE_TRIPLE;
        end else begin
          e_emit  = 1'b1;
          e_mode  = c_ts_pkg::M_DEFAULT;
          e_fresh = 1'b1;
        end
      end
      c_ts_pkg::M_MAYBE_TRIPLE: begin
        e_emit = 1'b1;
        e_mode = c_ts_pkg::M_DEFAULT;
        if (ch == c_ts_pkg::CH_EQ) begin
          e_len   = len_grow;
          e_lnext = len_grow;
          e_kind  = (kind_q == c_ts_pkg::K_SHL) ? c_ts_pkg::K_SHLEQ : c_ts_pkg::K_SHREQ;
        end else begin
          e_fresh = 1'b1;
        end
      end
      c_ts_pkg::M_MAYBE_DOTS: begin
        if (ch == c_ts_pkg::CH_DOT) begin
          e_lnext = len_grow;
          e_mode  = c_ts_pkg::M_NEED_DOT;
        end else begin
          e_emit  = 1'b1;
          e_kind  = c_ts_pkg::K_PERIOD;
          e_mode  = c_ts_pkg::M_DEFAULT;
          e_fresh = 1'b1;
        end
      end
      c_ts_pkg::M_NEED_DOT: begin
        e_emit = 1'b1;
        e_mode = c_ts_pkg::M_DEFAULT;
        if (ch == c_ts_pkg::CH_DOT) begin
          e_len   = len_grow;
          e_lnext = len_grow;
          e_kind  = c_ts_pkg::K_ELLIPSIS;
        end else begin
          // two dots and no third: bad ellipsis over the two dots
          e_kind   = c_ts_pkg::K_NONE;
          e_status = c_ts_pkg::ST_BAD_ELLIPSIS;
          e_fresh  = 1'b1;
        end
      end
      c_ts_pkg::M_IDENT: begin
        if (c_ts_pkg::is_alpha_us(ch) || c_ts_pkg::is_digit(ch)) begin
          e_lnext = len_grow;
        end else begin
          e_emit  = 1'b1;
          e_kind  = c_ts_pkg::K_IDENT;
          e_mode  = c_ts_pkg::M_DEFAULT;
          e_fresh = 1'b1;
        end
      end
      c_ts_pkg::M_INT: begin
        if (ch == c_ts_pkg::CH_DOT) begin
          e_lnext = len_grow;
          e_pkind = c_ts_pkg::K_FLOAT;
          e_mode  = c_ts_pkg::M_FLOAT;
        end else if (c_ts_pkg::is_digit(ch)) begin
          e_lnext = len_grow;
        end else begin
          e_emit  = 1'b1;
          e_kind  = c_ts_pkg::K_INT;
          e_mode  = c_ts_pkg::M_DEFAULT;
          e_fresh = 1'b1;
        end
      end
      c_ts_pkg::M_FLOAT: begin
        if (ch == c_ts_pkg::CH_LOW_F || ch == c_ts_pkg::CH_UP_F) begin
          e_emit  = 1'b1;
          e_len   = len_grow;
          e_lnext = len_grow;
          e_kind  = c_ts_pkg::K_FLOAT;
          e_mode  = c_ts_pkg::M_DEFAULT;
        end else if (c_ts_pkg::is_digit(ch)) begin
          e_lnext = len_grow;
        end else begin
          e_emit  = 1'b1;
          e_kind  = c_ts_pkg::K_FLOAT;
          e_mode  = c_ts_pkg::M_DEFAULT;
          e_fresh = 1'b1;
        end
      end
      c_ts_pkg::M_STRING: begin
        if (closed_q) begin
          // closing quote seen last byte: string ends before this one
          e_emit  = 1'b1;
          e_kind  = c_ts_pkg::K_STRING;
          e_mode  = c_ts_pkg::M_DEFAULT;
          e_fresh = 1'b1;
        end else begin
          e_lnext = len_grow;
          if (ch == c_ts_pkg::CH_DQUOTE && !esc_q) begin
            e_closed = 1'b1;
          end
          e_esc = (ch == c_ts_pkg::CH_BSLASH) && !esc_q;
        end
      end
      default: begin
        e_mode  = c_ts_pkg::M_DEFAULT;
        e_fresh = 1'b1;
      end
    endcase
  end

  // Scan the byte as the start of a new token
  always_comb begin
    c_ts_pkg::kind_hit_t sgl;
    c_ts_pkg::kind_hit_t dbl;
    sgl      = c_ts_pkg::single_kind(ch);
    dbl      = c_ts_pkg::double_kind(ch);
    f_emit   = 1'b0;
    f_kind   = c_ts_pkg::K_NONE;
    f_status = c_ts_pkg::ST_OK;
    f_begin  = 1'b0;
    f_bkind  = c_ts_pkg::K_NONE;
    f_bmode  = c_ts_pkg::M_DEFAULT;
    f_string = 1'b0;
    if (c_ts_pkg::is_space(ch)) begin
      f_emit = 1'b0;
    end else if (c_ts_pkg::is_alpha_us(ch)) begin
      f_begin = 1'b1;
      f_bkind = c_ts_pkg::K_IDENT;
      f_bmode = c_ts_pkg::M_IDENT;
    end else if (c_ts_pkg::is_digit(ch)) begin
      f_begin = 1'b1;
      f_bkind = c_ts_pkg::K_INT;
      f_bmode = c_ts_pkg::M_INT;
    end else if (ch == c_ts_pkg::CH_DQUOTE) begin
      f_begin  = 1'b1;
      f_bkind  = c_ts_pkg::K_STRING;
      f_bmode  = c_ts_pkg::M_STRING;
      f_string = 1'b1;
    end else if (ch == c_ts_pkg::CH_SQUOTE) begin
      f_emit   = 1'b1;
      f_status = c_ts_pkg::ST_CHAR_LIT;
    end else if (sgl.hit) begin
      f_emit = 1'b1;
      f_kind = sgl.kind;
    end else if (dbl.hit) begin
      f_begin = 1'b1;
      f_bkind = dbl.kind;
      f_bmode = c_ts_pkg::M_MAYBE_DOUBLE;
    end else if (ch == c_ts_pkg::CH_LT) begin
      f_begin = 1'b1;
      f_bkind = c_ts_pkg::K_LT;
      f_bmode = c_ts_pkg::M_MAYBE_DT;
    end else if (ch == c_ts_pkg::CH_GT) begin
      f_begin = 1'b1;
      f_bkind = c_ts_pkg::K_GT;
      f_bmode = c_ts_pkg::M_MAYBE_DT;
    end else if (ch == c_ts_pkg::CH_DOT) begin
      f_begin = 1'b1;
      f_bkind = c_ts_pkg::K_PERIOD;
      f_bmode = c_ts_pkg::M_MAYBE_DOTS;
    end else begin
      f_emit   = 1'b1;
      f_status = c_ts_pkg::ST_BAD_CHAR;
    end
  end

  // Next state
  always_comb begin
    mode_d   = mode_q;
    kind_d   = kind_q;
    start_d  = start_q;
    len_d    = len_q;
    off_d    = off_q;
    esc_d    = esc_q;
    closed_d = closed_q;
    if (accept) begin
      if (in_i.action == c_ts_pkg::ACT_EOI) begin
        // end of input: back to the reset state
        mode_d   = c_ts_pkg::M_DEFAULT;
        kind_d   = '0;
        start_d  = '0;
        len_d    = '0;
        off_d    = '0;
        esc_d    = 1'b0;
        closed_d = 1'b0;
      end else begin
        mode_d   = e_mode;
        kind_d   = e_pkind;
        len_d    = e_lnext;
        esc_d    = e_esc;
        closed_d = e_closed;
        if (do_fresh && f_begin) begin
          start_d = off_q;
          len_d   = LENGTH_BITS'(1);
          kind_d  = f_bkind;
          mode_d  = f_bmode;
          if (f_string) begin
            esc_d    = 1'b0;
            closed_d = 1'b0;
          end
        end
        off_d = off_q + OFFSET_BITS'(1);
      end
    end
  end

  // Results written to the queue
  always_comb begin
    c_ts_pkg::result_t pend;
    c_ts_pkg::result_t eof_res;
    c_ts_pkg::result_t ext_res;
    c_ts_pkg::result_t frs_res;
    logic              p_emit;
    p_emit  = 1'b1;
    pend    = mk_res(kind_q, start_q, len_q, c_ts_pkg::ST_OK);
    eof_res = mk_res(c_ts_pkg::K_EOF, off_q, '0, c_ts_pkg::ST_OK);
    ext_res = mk_res(e_kind, start_q, e_len, e_status);
    frs_res = mk_res(f_kind, off_q, LENGTH_BITS'(1), f_status);
    case (mode_q)
      c_ts_pkg::M_DEFAULT: p_emit = 1'b0;
      c_ts_pkg::M_NEED_DOT: begin
        pend = mk_res(c_ts_pkg::K_NONE, start_q, len_q, c_ts_pkg::ST_BAD_ELLIPSIS);
      end
      c_ts_pkg::M_STRING: begin
        if (!closed_q) begin
          pend = mk_res(c_ts_pkg::K_NONE, start_q, len_q, c_ts_pkg::ST_OPEN_STRING);
        end
      end
      default: p_emit = 1'b1;
    endcase

    push_o.cnt = 2'd0;
    push_o.r0  = frs_res;
    push_o.r1  = frs_res;
    if (accept) begin
      if (in_i.action == c_ts_pkg::ACT_EOI) begin
        push_o.r1 = eof_res;
        if (p_emit) begin
          push_o.cnt = 2'd2;
          push_o.r0  = pend;
        end else begin
          push_o.cnt = 2'd1;
          push_o.r0  = eof_res;
        end
      end else begin
        push_o.cnt = 2'(e_emit) + 2'(do_fresh && f_emit);
        if (e_emit) begin
          push_o.r0 = ext_res;
        end
      end
    end
    push_o.r0.last = (push_o.cnt == 2'd1);
    push_o.r1.last = 1'b1;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= c_ts_pkg::M_DEFAULT;
      kind_q   <= '0;
      start_q  <= '0;
      len_q    <= '0;
      off_q    <= '0;
      esc_q    <= 1'b0;
      closed_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      kind_q   <= kind_d;
      start_q  <= start_d;
      len_q    <= len_d;
      off_q    <= off_d;
      esc_q    <= esc_d;
      closed_q <= closed_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/c_ts_queue.sv =====
`default_nettype none

// Token queue: takes up to two words per cycle, gives one.
module c_ts_queue #(
  parameter int unsigned DEPTH = c_ts_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire c_ts_pkg::push_t    push_i,
  output logic                    space_ok_o,
  output c_ts_pkg::result_t       head_o,
  output logic                    avail_o,
  input  wire logic               pop_i
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  c_ts_pkg::result_t mem_q [DEPTH];
  logic [PtrW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [PtrW-1:0]   wp_one, wp_two;
  logic [CntW-1:0]   cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wp_one     = ptr_inc(wp_q);
  assign wp_two     = ptr_inc(wp_one);
  assign space_ok_o = (cnt_q <= CntW'(DEPTH - 2));
  assign avail_o    = (cnt_q != '0);
  assign head_o     = mem_q[rp_q];

  // Pointer and fill level update
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q + CntW'(push_i.cnt) - CntW'(pop_i);
    case (push_i.cnt)
      2'd1:    wp_d = wp_one;
      2'd2:    wp_d = wp_two;
      default: wp_d = wp_q;
    endcase
    if (pop_i) begin
      rp_d = ptr_inc(rp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wp_one] <= push_i.r1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/c_ts_back.sv =====
`default_nettype none

// Output stage: holds one token word for the receiver.
module c_ts_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire c_ts_pkg::result_t  head_i,
  input  wire logic               avail_i,
  output logic                    pop_o,
  c_ts_out_if.source              out_o
);

  logic              valid_q, valid_d;
  c_ts_pkg::result_t data_q;

  // Load a new word when the register is empty or being taken
  assign pop_o   = avail_i && (!valid_q || out_o.ready);
  assign valid_d = pop_o ? 1'b1 : (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.token_kind   = data_q.token_kind;
  assign out_o.start_offset = data_q.start_offset;
  assign out_o.token_length = data_q.token_length;
  assign out_o.status       = data_q.status;
  assign out_o.last         = data_q.last;

endmodule

`default_nettype wire

// ===== hdl/c_token_scanner.sv =====
// C token scanner.
// in_i carries one source byte per word (action 0) or the end-of-input mark
// (action 1). out_o carries tokens: kind, start offset, length, status and a
// last flag on the final token caused by each input word.
// Throughput: one input word per cycle. The scanner writes up to two tokens
// a cycle into a small queue; the output side drains one token a cycle, so
// a run of bytes that each close two tokens is limited by the output port.
// in_i.ready drops only while the queue has fewer than two free slots.
// A token closed by an accepted byte is written into the queue at the
// accepting edge and then moves into the output register when it is free.
// A stalled receiver holds the output register; the queue fills behind it
// and then backpressures in_i. Nothing is dropped.
// End of input flushes the pending token, gives the end-of-file token and
// returns the scanner to its reset state, so offsets restart at zero.
// Reset (rst_ni low, asynchronous) empties the queue and the output stage
// and clears the scanner state.
`default_nettype none

module c_token_scanner #(
  parameter int unsigned OFFSET_BITS = c_ts_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = c_ts_pkg::LENGTH_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = c_ts_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  c_ts_in_if.sink    in_i,
  c_ts_out_if.source out_o
);

  c_ts_pkg::push_t   push;
  c_ts_pkg::result_t head;
  logic              space_ok;
  logic              avail;
  logic              pop;

  c_ts_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  c_ts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .head_o     (head),
    .avail_o    (avail),
    .pop_i      (pop)
  );

  c_ts_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .avail_i (avail),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;
  import c_ts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned HOLD_AFTER  = 150;
  localparam int unsigned RAND_WORDS  = 1450;

  // One source word as the sender offers it
  typedef struct {
    logic        act;
    logic [7:0]  ch;
    int unsigned gap;
    logic        drain;
  } src_word_t;

  logic clk_i;
  logic rst_ni;

  c_ts_in_if  in_bus ();
  c_ts_out_if out_bus ();

  c_token_scanner i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Scanner state as the predictor sees it
  mode_e               sc_mode;
  logic [KIND_W-1:0]   sc_kind;
  logic [START_W-1:0]  sc_start;
  logic [LEN_W-1:0]    sc_len;
  logic [START_W-1:0]  sc_off;
  logic                sc_esc;
  logic                sc_closed;

  result_t     step_toks[$];
  result_t     tokens_due[$];
  src_word_t   src_words[$];

  int unsigned cyc_count;
  int unsigned fail_cnt;
  int unsigned words_taken;
  int unsigned total_words;
  int unsigned tok_checked;
  logic        gen_calm;

  string punct_txt[] = '{"(", ")", "{", "}", "[", "]", ";", ":", ",", "~", "?",
                         "!", "+", "-", "*", "/", "%", "&", "|", "^", "=",
                         "!=", "+=", "-=", "*=", "/=", "%=", "&=", "|=", "^=",
                         "==", "++", "--", "->", "&&", "||", "<", ">", "<=",
                         ">=", "<<", ">>", "<<=", ">>=", ".", "...", ".."};
  logic [7:0] blank_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  // ---------------------------------------------------------------------------
  // Character classes and punctuator lookups
  // ---------------------------------------------------------------------------
  function automatic logic digit_ch(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic alpha_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_USCORE;
  endfunction

  function automatic logic blank_ch(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // -1 when c is not a one-character punctuator
  function automatic int single_code(input logic [7:0] c);
    case (c)
      "(":     return K_LPAREN;
      ")":     return K_RPAREN;
      "{":     return K_LBRACE;
      "}":     return K_RBRACE;
      "[":     return K_LBRACK;
      "]":     return K_RBRACK;
      ";":     return K_SEMI;
      ":":     return K_COLON;
      ",":     return K_COMMA;
      "~":     return K_TILDE;
      "?":     return K_QUEST;
      default: return -1;
    endcase
  endfunction

  // -1 when c is not one of ! + - * / % & | ^ =
  function automatic int pair_code(input logic [7:0] c);
    case (c)
      "!":      return K_NOT;
      CH_PLUS:  return K_PLUS;
      CH_MINUS: return K_MINUS;
      "*":      return K_STAR;
      "/":      return K_SLASH;
      "%":      return K_PCT;
      CH_AMP:   return K_AMP;
      CH_BAR:   return K_OR;
      "^":      return K_XOR;
      CH_EQ:    return K_ASSIGN;
      default:  return -1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  task automatic clear_scan();
    sc_mode   = M_DEFAULT;
    sc_kind   = '0;
    sc_start  = '0;
    sc_len    = '0;
    sc_off    = '0;
    sc_esc    = 1'b0;
    sc_closed = 1'b0;
  endtask

  task automatic note_tok(input logic [KIND_W-1:0] k, input logic [START_W-1:0] s,
                          input logic [LEN_W-1:0] l, input logic [STATUS_W-1:0] st);
    result_t r;
    r.token_kind   = k;
    r.start_offset = s;
    r.token_length = l;
    r.status       = st;
    r.last         = 1'b0;
    step_toks.push_back(r);
  endtask

  task automatic open_tok(input logic [KIND_W-1:0] k, input mode_e m);
    sc_start = sc_off;
    sc_len   = LEN_W'(1);
    sc_kind  = k;
    sc_mode  = m;
  endtask

  task automatic close_tok(input logic [KIND_W-1:0] k);
    note_tok(k, sc_start, sc_len, ST_OK);
    sc_mode = M_DEFAULT;
  endtask

  // length saturates at all ones
  task automatic lengthen();
    if (sc_len != '1) sc_len = sc_len + 1'b1;
  endtask

  task automatic start_fresh(input logic [7:0] c);
    int sk;
    int pk;
    sk = single_code(c);
    pk = pair_code(c);
    if (blank_ch(c)) begin
    end else if (alpha_ch(c)) begin
      open_tok(K_IDENT, M_IDENT);
    end else if (digit_ch(c)) begin
      open_tok(K_INT, M_INT);
    end else if (c == CH_DQUOTE) begin
      open_tok(K_STRING, M_STRING);
      sc_esc    = 1'b0;
      sc_closed = 1'b0;
    end else if (c == CH_SQUOTE) begin
      note_tok(K_NONE, sc_off, LEN_W'(1), ST_CHAR_LIT);
    end else if (sk >= 0) begin
      note_tok(sk[KIND_W-1:0], sc_off, LEN_W'(1), ST_OK);
    end else if (pk >= 0) begin
      open_tok(pk[KIND_W-1:0], M_MAYBE_DOUBLE);
    end else if (c == CH_LT) begin
      open_tok(K_LT, M_MAYBE_DT);
    end else if (c == CH_GT) begin
      open_tok(K_GT, M_MAYBE_DT);
    end else if (c == CH_DOT) begin
      open_tok(K_PERIOD, M_MAYBE_DOTS);
    end else begin
      note_tok(K_NONE, sc_off, LEN_W'(1), ST_BAD_CHAR);
    end
  endtask

  // Offers c to the pending token; again is set when c must start afresh
  task automatic feed_pending(input logic [7:0] c, output logic again);
    logic [KIND_W-1:0] k;
    logic              joined;
    k      = sc_kind;
    again  = 1'b0;
    joined = 1'b1;
    case (sc_mode)
      M_MAYBE_DOUBLE: begin
        if (c == CH_EQ) k = k + K_EQ_SHIFT;
        else if (c == CH_PLUS && k == K_PLUS) k = K_INC;
        else if (c == CH_MINUS && k == K_MINUS) k = K_DEC;
        else if (c == CH_GT && k == K_MINUS) k = K_ARROW;
        else if (c == CH_AMP && k == K_AMP) k = K_LAND;
        else if (c == CH_BAR && k == K_OR) k = K_LOR;
        else joined = 1'b0;
        if (joined) begin
          lengthen();
          close_tok(k);
        end else begin
          close_tok(k);
          again = 1'b1;
        end
      end
      M_MAYBE_DT: begin
        if (c == CH_EQ) begin
          lengthen();
          close_tok(k == K_LT ? K_LE : K_GE);
        end else if ((c == CH_LT && k == K_LT) || (c == CH_GT && k == K_GT)) begin
          lengthen();
          sc_kind = (k == K_LT) ? K_SHL : K_SHR;
          sc_mode = M_MAYBE_TRIPLE;
        end else begin
          close_tok(k);
          again = 1'b1;
        end
      end
      M_MAYBE_TRIPLE: begin
        if (c == CH_EQ) begin
          lengthen();
          close_tok(k == K_SHL ? K_SHLEQ : K_SHREQ);
        end else begin
          close_tok(k);
          again = 1'b1;
        end
      end
      M_MAYBE_DOTS: begin
        if (c == CH_DOT) begin
          lengthen();
          sc_mode = M_NEED_DOT;
        end else begin
          close_tok(K_PERIOD);
          again = 1'b1;
        end
      end
      M_NEED_DOT: begin
        if (c == CH_DOT) begin
          lengthen();
          close_tok(K_ELLIPSIS);
        end else begin
          note_tok(K_NONE, sc_start, sc_len, ST_BAD_ELLIPSIS);
          sc_mode = M_DEFAULT;
          again   = 1'b1;
        end
      end
      M_IDENT: begin
        if (alpha_ch(c) || digit_ch(c)) lengthen();
        else begin
          close_tok(K_IDENT);
          again = 1'b1;
        end
      end
      M_INT: begin
        if (c == CH_DOT) begin
          lengthen();
          sc_kind = K_FLOAT;
          sc_mode = M_FLOAT;
        end else if (digit_ch(c)) begin
          lengthen();
        end else begin
          close_tok(K_INT);
          again = 1'b1;
        end
      end
      M_FLOAT: begin
        if (c == CH_LOW_F || c == CH_UP_F) begin
          lengthen();
          close_tok(K_FLOAT);
        end else if (digit_ch(c)) begin
          lengthen();
        end else begin
          close_tok(K_FLOAT);
          again = 1'b1;
        end
      end
      M_STRING: begin
        if (sc_closed) begin
          close_tok(K_STRING);
          again = 1'b1;
        end else begin
          lengthen();
          if (c == CH_DQUOTE && !sc_esc) sc_closed = 1'b1;
          // a backslash escapes only the next byte
          sc_esc = (c == CH_BSLASH) && !sc_esc;
        end
      end
      default: begin
        sc_mode = M_DEFAULT;
        again   = 1'b1;
      end
    endcase
  endtask

  // Predicts the tokens caused by one accepted word and queues them
  task automatic lex_word(input logic act, input logic [7:0] c);
    logic    again;
    result_t r;
    step_toks.delete();
    if (act == ACT_EOI) begin
      case (sc_mode)
        M_DEFAULT: begin
        end
        M_NEED_DOT: note_tok(K_NONE, sc_start, sc_len, ST_BAD_ELLIPSIS);
        M_STRING: begin
          if (sc_closed) note_tok(K_STRING, sc_start, sc_len, ST_OK);
          else note_tok(K_NONE, sc_start, sc_len, ST_OPEN_STRING);
        end
        default: note_tok(sc_kind, sc_start, sc_len, ST_OK);
      endcase
      note_tok(K_EOF, sc_off, '0, ST_OK);
      clear_scan();
    end else begin
      again = 1'b1;
      if (sc_mode != M_DEFAULT) feed_pending(c, again);
      if (again) start_fresh(c);
      sc_off = sc_off + 1'b1;
    end
    foreach (step_toks[i]) begin
      r      = step_toks[i];
      r.last = (i == step_toks.size() - 1);
      tokens_due.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_word(input logic act, input logic [7:0] c, input logic drain);
    src_word_t w;
    w.act   = act;
    w.ch    = c;
    w.gap   = gen_calm ? 0 : pick_gap();
    w.drain = drain;
    src_words.push_back(w);
  endtask

  task automatic add_char(input logic [7:0] c);
    add_word(ACT_CHAR, c, 1'b0);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [7:0] ident_char(input logic lead);
    int unsigned r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + (r - 26));
    if (r == 52) return CH_USCORE;
    return 8'(8'h30 + (r - 53));
  endfunction

  function automatic logic [7:0] digit_pick();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] text_pick();
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // One well-formed token (or a bit of noise), maybe followed by whitespace
  task automatic add_token();
    int unsigned n;
    logic [7:0]  c;
    case ($urandom_range(0, 11))
      0, 1: begin
        n = $urandom_range(1, 8);
        add_char(ident_char(1'b1));
        repeat (n - 1) add_char(ident_char(1'b0));
      end
      2: repeat ($urandom_range(1, 5)) add_char(digit_pick());
      3: begin
        repeat ($urandom_range(1, 3)) add_char(digit_pick());
        add_char(CH_DOT);
        repeat ($urandom_range(0, 3)) add_char(digit_pick());
        case ($urandom_range(0, 2))
          1: add_char(CH_LOW_F);
          2: add_char(CH_UP_F);
          default: begin
          end
        endcase
      end
      4: begin
        add_char(CH_DQUOTE);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 4) == 0) begin
            add_char(CH_BSLASH);
            add_char(text_pick());
          end else begin
            c = text_pick();
            if (c == CH_DQUOTE || c == CH_BSLASH) c = "a";
            add_char(c);
          end
        end
        add_char(CH_DQUOTE);
      end
      8: add_char(CH_SQUOTE);
      9: add_char(8'($urandom_range(0, 255)));
      11: add_char(8'($urandom_range(128, 255)));
      default: add_text(punct_txt[$urandom_range(0, punct_txt.size() - 1)]);
    endcase
    if ($urandom_range(0, 9) < 6)
      repeat ($urandom_range(1, 2)) add_char(blank_set[$urandom_range(0, 5)]);
  endtask

  task automatic build_stimulus();
    int unsigned base;
    int unsigned seg;
    logic        drain;
    gen_calm = 1'b0;

    // directed: escapes, bad char after a closed string, char literal,
    // bad ellipsis, f suffix, three-character shift, NUL, ".." at the end
    add_text("a1 \"x\\\"\"");
    add_char(8'hFF);
    add_text("'..;1.5f>>=");
    add_char(8'h00);
    add_text("..");
    add_word(ACT_EOI, 8'hA5, 1'b0);
    // unclosed string at end of input, sent once everything is back
    add_word(ACT_CHAR, CH_DQUOTE, 1'b1);
    add_char("a");
    add_word(ACT_EOI, 8'h5A, 1'b0);

    // random source text, split into files by end-of-input words
    base = src_words.size();
    seg  = 0;
    while (src_words.size() - base < RAND_WORDS) begin
      gen_calm = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(3, 25)) add_token();
      if ($urandom_range(0, 3) == 0) begin
        add_char(CH_DQUOTE);
        repeat ($urandom_range(0, 3)) add_char(text_pick());
      end
      drain = (seg == 0) || ($urandom_range(0, 2) == 0);
      add_word(ACT_EOI, 8'($urandom_range(0, 255)), drain);
      seg++;
    end
    total_words = src_words.size();
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset, cycle count
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc_count <= cyc_count + 1;

  initial begin
    wait (cyc_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: offers words from the queue, with gaps and drain pauses
  // ---------------------------------------------------------------------------
  src_word_t   cur;
  logic        loaded;
  logic        offering;
  logic        offer_taken;
  int unsigned gap_left;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (offer_taken) begin
        offer_taken = 1'b0;
        offering    = 1'b0;
      end
      if (!offering) begin
        if (!loaded && src_words.size() > 0) begin
          cur      = src_words.pop_front();
          gap_left = cur.gap;
          loaded   = 1'b1;
        end
        if (!loaded) begin
          in_bus.valid <= 1'b0;
        end else if (gap_left > 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (cur.drain && tokens_due.size() != 0) begin
          in_bus.valid <= 1'b0;
        end else begin
          in_bus.valid     <= 1'b1;
          in_bus.action    <= cur.act;
          in_bus.char_byte <= cur.ch;
          offering = 1'b1;
          loaded   = 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and one long hold-off
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  logic        rcv_calm;
  logic        long_hold_done;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cyc_count % 256 == 0) rcv_calm = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!long_hold_done && tok_checked >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD - 1;
        out_bus.ready <= 1'b0;
      end else if (!rcv_calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_bus.ready <= (stall_left == 0);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check tokens against the oldest prediction, then predict
  // ---------------------------------------------------------------------------
  result_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        if (tokens_due.size() == 0) begin
          $error("token_kind: expected no word, actual %0d", out_bus.token_kind);
          fail_cnt++;
        end else begin
          want = tokens_due.pop_front();
          tok_checked++;
          if (out_bus.token_kind !== want.token_kind) begin
            $error("token_kind: expected %0d, actual %0d", want.token_kind,
                   out_bus.token_kind);
            fail_cnt++;
          end
          if (out_bus.start_offset !== want.start_offset) begin
            $error("start_offset: expected %0d, actual %0d", want.start_offset,
                   out_bus.start_offset);
            fail_cnt++;
          end
          if (out_bus.token_length !== want.token_length) begin
            $error("token_length: expected %0d, actual %0d", want.token_length,
                   out_bus.token_length);
            fail_cnt++;
          end
          if (out_bus.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_bus.status);
            fail_cnt++;
          end
          if (out_bus.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_bus.last);
            fail_cnt++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        lex_word(in_bus.action, in_bus.char_byte);
        offer_taken = 1'b1;
        words_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.action     = ACT_CHAR;
    in_bus.char_byte  = '0;
    out_bus.ready     = 1'b0;
    cyc_count         = 0;
    fail_cnt          = 0;
    words_taken       = 0;
    tok_checked       = 0;
    loaded            = 1'b0;
    offering          = 1'b0;
    offer_taken       = 1'b0;
    gap_left          = 0;
    stall_left        = 0;
    rcv_calm          = 1'b0;
    long_hold_done    = 1'b0;
    clear_scan();
    build_stimulus();

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (words_taken != total_words || tokens_due.size() != 0) @(posedge clk_i);
    // leave room for any stray token
    repeat (10) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
